// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME_CYCLE(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT_CYCLE(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// ===== rtl/bdq_pkg.sv =====
// shared types, codes and defaults for the delay bin event queue
// no dependencies; imported by every module of the block
`default_nettype none

package bdq_pkg;

    // parameter defaults
    localparam int NUM_BINS_DEF     = 16;
    localparam int BIN_CAPACITY_DEF = 64;
    localparam int TARGET_WIDTH_DEF = 16;

    // fixed field widths of the ports
    localparam int TGT_PORT_W = 16;
    localparam int DELAY_W    = 4;
    localparam int CFG_W      = 5;

    // active_bins after reset
    localparam logic [CFG_W-1:0] ACTIVE_BINS_RST = 5'd16;

    // command modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic                  mode;
        logic [TGT_PORT_W-1:0] target_in;
        logic [DELAY_W-1:0]    delay_ticks;
        logic                  batch_last;
    } cmd_t;

    typedef struct packed {
        kind_t                 result_kind;
        logic [TGT_PORT_W-1:0] target_out;
        status_t               status;
        logic                  last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_INSERT,
        ST_TICK_START,
        ST_TICK_STREAM
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/delay_bin_event_queue.sv =====
// top level of the delay bin event queue: config register and memories
// depends on bdq_pkg, bdq_ctrl, bdq_fill_ram, bdq_entry_ram
//
// A command is taken when start is high and busy is low; each result shows on
// rsp for exactly one cycle with rsp_strobe high, and the receiver cannot
// stall. An insert whose delay is beyond the bins in use answers from idle.
// Any other insert first wraps slot + delay by the bins in use (one
// subtraction per cycle), followed by a read-modify-write of the bin's fill
// count in the fill memory. A tick reads the fill count of the current bin
// and wraps the next slot, then the entry memory's single read port streams
// one target per cycle (an empty bin gives one empty marker). Results are
// registered and may overlap the acceptance of the next command. cfg_ready
// is always high; write active_bins only while the block is idle. Fill counts
// reset through per-bin valid flops, so no clearing pass follows reset.
`default_nettype none

module delay_bin_event_queue
    import bdq_pkg::*;
#(
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int BIN_CAPACITY = BIN_CAPACITY_DEF,
    parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire cmd_t             cmd,
    output logic                  rsp_strobe,
    output rsp_t                  rsp,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(NUM_BINS);
    localparam int FILL_W = $clog2(BIN_CAPACITY + 1);
    localparam int IDX_W  = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1;
    localparam int ADDR_W = SLOT_W + IDX_W;

    logic [CFG_W-1:0]        active_bins_reg;

    logic                    fill_rd_en;
    logic [SLOT_W-1:0]       fill_rd_bin;
    logic [FILL_W-1:0]       fill_rd_count;
    logic                    fill_wr_en;
    logic [SLOT_W-1:0]       fill_wr_bin;
    logic [FILL_W-1:0]       fill_wr_count;
    logic                    fill_clr_en;
    logic [SLOT_W-1:0]       fill_clr_bin;
    logic                    ent_wr_en;
    logic [ADDR_W-1:0]       ent_wr_addr;
    logic [TARGET_WIDTH-1:0] ent_wr_data;
    logic                    ent_rd_en;
    logic [ADDR_W-1:0]       ent_rd_addr;
    logic [TARGET_WIDTH-1:0] ent_rd_data;

    assign cfg_ready = 1'b1;

    // active_bins register, one beat per write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bins_reg <= ACTIVE_BINS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_bins_reg <= cfg_data;
        end
    end

    // sequencer
    bdq_ctrl #(
        .NUM_BINS     (NUM_BINS),
        .BIN_CAPACITY (BIN_CAPACITY),
        .TARGET_WIDTH (TARGET_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .active_bins   (active_bins_reg),
        .rsp_strobe    (rsp_strobe),
        .rsp           (rsp),
        .fill_rd_en    (fill_rd_en),
        .fill_rd_bin   (fill_rd_bin),
        .fill_rd_count (fill_rd_count),
        .fill_wr_en    (fill_wr_en),
        .fill_wr_bin   (fill_wr_bin),
        .fill_wr_count (fill_wr_count),
        .fill_clr_en   (fill_clr_en),
        .fill_clr_bin  (fill_clr_bin),
        .ent_wr_en     (ent_wr_en),
        .ent_wr_addr   (ent_wr_addr),
        .ent_wr_data   (ent_wr_data),
        .ent_rd_en     (ent_rd_en),
        .ent_rd_addr   (ent_rd_addr),
        .ent_rd_data   (ent_rd_data)
    );

    // fill counts
    bdq_fill_ram #(
        .NUM_BINS     (NUM_BINS),
        .BIN_CAPACITY (BIN_CAPACITY)
    ) u_fill (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (fill_rd_en),
        .rd_bin   (fill_rd_bin),
        .rd_count (fill_rd_count),
        .wr_en    (fill_wr_en),
        .wr_bin   (fill_wr_bin),
        .wr_count (fill_wr_count),
        .clr_en   (fill_clr_en),
        .clr_bin  (fill_clr_bin)
    );

    // stored targets
    bdq_entry_ram #(
        .NUM_BINS     (NUM_BINS),
        .BIN_CAPACITY (BIN_CAPACITY),
        .TARGET_WIDTH (TARGET_WIDTH)
    ) u_entry (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/bdq_fill_ram.sv =====
// per-bin fill count memory with one valid flop per bin
// depends on bdq_pkg; an invalid bin reads as an empty count
`default_nettype none

module bdq_fill_ram
    import bdq_pkg::*;
#(
    parameter int   NUM_BINS     = NUM_BINS_DEF,
    parameter int   BIN_CAPACITY = BIN_CAPACITY_DEF,
    localparam int  SLOT_W       = $clog2(NUM_BINS),
    localparam int  FILL_W       = $clog2(BIN_CAPACITY + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [SLOT_W-1:0] rd_bin,
    output logic      [FILL_W-1:0] rd_count,
    input  wire logic              wr_en,
    input  wire logic [SLOT_W-1:0] wr_bin,
    input  wire logic [FILL_W-1:0] wr_count,
    input  wire logic              clr_en,
    input  wire logic [SLOT_W-1:0] clr_bin
);

    logic [FILL_W-1:0]   fill_mem [0:NUM_BINS-1];
    logic [NUM_BINS-1:0] valid_reg;
    logic [FILL_W-1:0]   rd_count_reg;

    // count storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fill_mem[wr_bin] <= wr_count;
        end
        if (rd_en)
        begin
            rd_count_reg <= valid_reg[rd_bin] ? fill_mem[rd_bin] : '0;
        end
    end

    // valid bits: set by a count write, cleared when a tick drains the bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_bin] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_bin] <= 1'b0;
            end
        end
    end

    assign rd_count = rd_count_reg;

endmodule

`default_nettype wire

// ===== rtl/bdq_entry_ram.sv =====
// target entry memory, one row of slots per bin
// depends on bdq_pkg; single write port, single registered read port
`default_nettype none

module bdq_entry_ram
    import bdq_pkg::*;
#(
    parameter int   NUM_BINS     = NUM_BINS_DEF,
    parameter int   BIN_CAPACITY = BIN_CAPACITY_DEF,
    parameter int   TARGET_WIDTH = TARGET_WIDTH_DEF,
    localparam int  SLOT_W       = $clog2(NUM_BINS),
    localparam int  IDX_W        = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1,
    localparam int  ADDR_W       = SLOT_W + IDX_W,
    localparam int  DEPTH        = NUM_BINS << IDX_W
)
(
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [ADDR_W-1:0]       wr_addr,
    input  wire logic [TARGET_WIDTH-1:0] wr_data,
    input  wire logic                    rd_en,
    input  wire logic [ADDR_W-1:0]       rd_addr,
    output logic      [TARGET_WIDTH-1:0] rd_data
);

    logic [TARGET_WIDTH-1:0] entry_mem [0:DEPTH-1];
    logic [TARGET_WIDTH-1:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
// sequencer: slot arithmetic, read-modify-write of fill counts, bin drain
// depends on bdq_pkg; drives bdq_fill_ram and bdq_entry_ram
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
#(
    parameter int   NUM_BINS     = NUM_BINS_DEF,
    parameter int   BIN_CAPACITY = BIN_CAPACITY_DEF,
    parameter int   TARGET_WIDTH = TARGET_WIDTH_DEF,
    localparam int  SLOT_W       = $clog2(NUM_BINS),
    localparam int  FILL_W       = $clog2(BIN_CAPACITY + 1),
    localparam int  IDX_W        = (BIN_CAPACITY > 1) ? $clog2(BIN_CAPACITY) : 1,
    localparam int  ADDR_W       = SLOT_W + IDX_W
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire cmd_t                    cmd,
    input  wire logic [CFG_W-1:0]        active_bins,
    output logic                         rsp_strobe,
    output rsp_t                         rsp,
    output logic                         fill_rd_en,
    output logic      [SLOT_W-1:0]       fill_rd_bin,
    input  wire logic [FILL_W-1:0]       fill_rd_count,
    output logic                         fill_wr_en,
    output logic      [SLOT_W-1:0]       fill_wr_bin,
    output logic      [FILL_W-1:0]       fill_wr_count,
    output logic                         fill_clr_en,
    output logic      [SLOT_W-1:0]       fill_clr_bin,
    output logic                         ent_wr_en,
    output logic      [ADDR_W-1:0]       ent_wr_addr,
    output logic      [TARGET_WIDTH-1:0] ent_wr_data,
    output logic                         ent_rd_en,
    output logic      [ADDR_W-1:0]       ent_rd_addr,
    input  wire logic [TARGET_WIDTH-1:0] ent_rd_data
);

    localparam int SUM_W = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;

    state_t                  state_reg,    state_next;
    logic [SLOT_W-1:0]       slot_reg,     slot_next;
    logic [SUM_W-1:0]        sum_reg,      sum_next;
    logic                    mode_reg,     mode_next;
    logic [TARGET_WIDTH-1:0] target_reg,   target_next;
    logic [FILL_W-1:0]       n_reg,        n_next;
    logic [FILL_W-1:0]       rd_cnt_reg,   rd_cnt_next;
    logic [FILL_W-1:0]       emit_cnt_reg, emit_cnt_next;
    logic                    strobe_reg,   strobe_next;
    rsp_t                    rsp_reg,      rsp_next;

    logic [CFG_W-1:0]        use_bins;
    logic [SUM_W-1:0]        use_ext;
    logic                    emit_last;

    // bins in use, clamped to one and to the wheel size
    always_comb
    begin
        if (active_bins == '0)
        begin
            use_bins = CFG_W'(1);
        end
        else if (int'(active_bins) > NUM_BINS)
        begin
            use_bins = CFG_W'(NUM_BINS);
        end
        else
        begin
            use_bins = active_bins;
        end
    end

    assign use_ext   = SUM_W'(use_bins);
    assign emit_last = (FILL_W'(emit_cnt_reg + 1'b1) == n_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            slot_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            strobe_reg <= strobe_next;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        mode_reg     <= mode_next;
        target_reg   <= target_next;
        n_reg        <= n_next;
        rd_cnt_reg   <= rd_cnt_next;
        emit_cnt_reg <= emit_cnt_next;
        rsp_reg      <= rsp_next;
    end

    // next state, memory accesses and results
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        sum_next      = sum_reg;
        mode_next     = mode_reg;
        target_next   = target_reg;
        n_next        = n_reg;
        rd_cnt_next   = rd_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        strobe_next   = 1'b0;
        rsp_next      = rsp_reg;

        fill_rd_en    = 1'b0;
        fill_rd_bin   = slot_reg;
        fill_wr_en    = 1'b0;
        fill_wr_bin   = sum_reg[SLOT_W-1:0];
        fill_wr_count = FILL_W'(fill_rd_count + 1'b1);
        fill_clr_en   = 1'b0;
        fill_clr_bin  = slot_reg;
        ent_wr_en     = 1'b0;
        ent_wr_addr   = {sum_reg[SLOT_W-1:0], fill_rd_count[IDX_W-1:0]};
        ent_wr_data   = target_reg;
        ent_rd_en     = 1'b0;
        ent_rd_addr   = {slot_reg, rd_cnt_reg[IDX_W-1:0]};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = cmd.mode;
                    target_next = TARGET_WIDTH'(cmd.target_in);
                    if (cmd.mode == MODE_TICK)
                    begin
                        // fetch the count of the bin to drain, compute the next slot
                        fill_rd_en = 1'b1;
                        sum_next   = SUM_W'(slot_reg) + SUM_W'(1);
                        state_next = ST_REDUCE;
                    end
                    else if (SUM_W'(cmd.delay_ticks) >= use_ext)
                    begin
                        // delay beyond the wheel: drop at once
                        strobe_next          = 1'b1;
                        rsp_next.result_kind = KIND_ACK;
                        rsp_next.target_out  = '0;
                        rsp_next.status      = STAT_RANGE;
                        rsp_next.last        = 1'b1;
                    end
                    else
                    begin
                        sum_next   = SUM_W'(slot_reg) + SUM_W'(cmd.delay_ticks);
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                // wrap by repeated subtraction of the bins in use
                if (sum_reg >= use_ext)
                begin
                    sum_next = sum_reg - use_ext;
                end
                else if (mode_reg == MODE_INSERT)
                begin
                    fill_rd_en  = 1'b1;
                    fill_rd_bin = sum_reg[SLOT_W-1:0];
                    state_next  = ST_INSERT;
                end
                else
                begin
                    state_next = ST_TICK_START;
                end
            end

            ST_INSERT:
            begin
                strobe_next          = 1'b1;
                rsp_next.result_kind = KIND_ACK;
                rsp_next.target_out  = '0;
                rsp_next.last        = 1'b1;
                if (fill_rd_count >= FILL_W'(BIN_CAPACITY))
                begin
                    rsp_next.status = STAT_FULL;
                end
                else
                begin
                    // append the target and bump the count
                    rsp_next.status = STAT_OK;
                    ent_wr_en       = 1'b1;
                    fill_wr_en      = 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_TICK_START:
            begin
                n_next = fill_rd_count;
                if (fill_rd_count == '0)
                begin
                    // empty bin marker
                    strobe_next          = 1'b1;
                    rsp_next.result_kind = KIND_EMPTY;
                    rsp_next.target_out  = '0;
                    rsp_next.status      = STAT_OK;
                    rsp_next.last        = 1'b1;
                    fill_clr_en          = 1'b1;
                    slot_next            = sum_reg[SLOT_W-1:0];
                    state_next           = ST_IDLE;
                end
                else
                begin
                    ent_rd_en     = 1'b1;
                    ent_rd_addr   = {slot_reg, IDX_W'(0)};
                    rd_cnt_next   = FILL_W'(1);
                    emit_cnt_next = '0;
                    state_next    = ST_TICK_STREAM;
                end
            end

            ST_TICK_STREAM:
            begin
                // one target per cycle, next read issued behind it
                strobe_next          = 1'b1;
                rsp_next.result_kind = KIND_TARGET;
                rsp_next.target_out  = TGT_PORT_W'(ent_rd_data);
                rsp_next.status      = STAT_OK;
                rsp_next.last        = emit_last;
                emit_cnt_next        = FILL_W'(emit_cnt_reg + 1'b1);
                if (rd_cnt_reg < n_reg)
                begin
                    ent_rd_en   = 1'b1;
                    rd_cnt_next = FILL_W'(rd_cnt_reg + 1'b1);
                end
                if (emit_last)
                begin
                    fill_clr_en = 1'b1;
                    slot_next   = sum_reg[SLOT_W-1:0];
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign rsp_strobe = strobe_reg;
    assign rsp        = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/bdq_checker.sv =====
// port-level checks of the delay bin event queue, bound to the top level
// depends on bdq_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire cmd_t cmd,
    input wire logic rsp_strobe,
    input wire rsp_t rsp
);

    // acknowledgements and empty markers each close their command
    `ASSERT_SAME_CYCLE(a_single_is_last, clk, rst_n, rsp_strobe && (rsp.result_kind != KIND_TARGET), rsp.last)

    // only acknowledgements carry a nonzero status
    `ASSERT_SAME_CYCLE(a_tick_status_ok, clk, rst_n, rsp_strobe && (rsp.result_kind != KIND_ACK), rsp.status == STAT_OK)

    // a drain that is not finished keeps the block busy
    `ASSERT_SAME_CYCLE(a_stream_busy, clk, rst_n, rsp_strobe && !rsp.last, busy)

    // a tick always needs the slot update before it can finish
    `ASSERT_NEXT_CYCLE(a_tick_goes_busy, clk, rst_n, start && !busy && (cmd.mode == MODE_TICK), busy)

endmodule

bind delay_bin_event_queue bdq_checker u_bdq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .rsp_strobe (rsp_strobe),
    .rsp        (rsp)
);

`default_nettype wire

// ===== test/bdq_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the delay bin event queue: watches command, result and config beats
// predicts each result from its own timing wheel copy; depends on bdq_pkg

module bdq_scoreboard
    import bdq_pkg::*;
#(
    parameter int NUM_BINS     = NUM_BINS_DEF,
    parameter int BIN_CAPACITY = BIN_CAPACITY_DEF,
    parameter int TARGET_WIDTH = TARGET_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire cmd_t             cmd,
    input  wire logic             rsp_strobe,
    input  wire rsp_t             rsp,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    results_seen,
    output int                    full_drops,
    output int                    range_drops
);

    // shadow copy of the wheel
    logic [CFG_W-1:0]      wheel_size;
    logic [TGT_PORT_W-1:0] bin_targets [NUM_BINS][BIN_CAPACITY];
    int                    bin_count [NUM_BINS];
    int                    cur_slot;
    rsp_t                  due_results [$];

    // apply one accepted command to the shadow wheel, queue the results it causes
    function automatic void advance_wheel(input cmd_t c);
        int                    bins_used;
        int                    bin;
        int                    n;
        rsp_t                  r;
        logic [TGT_PORT_W-1:0] tmask;
        tmask = '1;
        if (TARGET_WIDTH < TGT_PORT_W)
        begin
            tmask = TGT_PORT_W'((1 << TARGET_WIDTH) - 1);
        end
        // register value 0 acts as one bin, values past the wheel clamp to it
        bins_used = int'(wheel_size);
        if (bins_used < 1)
        begin
            bins_used = 1;
        end
        if (bins_used > NUM_BINS)
        begin
            bins_used = NUM_BINS;
        end
        if (c.mode == MODE_INSERT)
        begin
            r.result_kind = KIND_ACK;
            r.target_out  = '0;
            r.last        = 1'b1;
            if (int'(c.delay_ticks) >= bins_used)
            begin
                // range check wins over a full bin
                r.status = STAT_RANGE;
            end
            else
            begin
                bin = (cur_slot + int'(c.delay_ticks)) % bins_used;
                if (bin_count[bin] >= BIN_CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    bin_targets[bin][bin_count[bin]] = c.target_in & tmask;
                    bin_count[bin]++;
                    r.status = STAT_OK;
                end
            end
            due_results.push_back(r);
        end
        else
        begin
            // tick: drain the current bin in insertion order
            n = bin_count[cur_slot];
            r.status = STAT_OK;
            if (n == 0)
            begin
                r.result_kind = KIND_EMPTY;
                r.target_out  = '0;
                r.last        = 1'b1;
                due_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    r.result_kind = KIND_TARGET;
                    r.target_out  = bin_targets[cur_slot][i];
                    r.last        = (i == n - 1);
                    due_results.push_back(r);
                end
            end
            bin_count[cur_slot] = 0;
            cur_slot = (cur_slot + 1) % bins_used;
        end
    endfunction

    // compare result beats, track config writes, predict on command beats
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            wheel_size = ACTIVE_BINS_RST;
            for (int b = 0; b < NUM_BINS; b++)
            begin
                bin_count[b] = 0;
            end
            cur_slot = 0;
            due_results.delete();
            fail_count   = 0;
            results_seen = 0;
            full_drops   = 0;
            range_drops  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_strobe)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result kind=%0d target=%h status=%0d last=%b",
                             $time, rsp.result_kind, rsp.target_out, rsp.status, rsp.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.result_kind !== want.result_kind
                        || rsp.target_out !== want.target_out
                        || rsp.status !== want.status
                        || rsp.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected kind=%0d target=%h status=%0d last=%b",
                                 $time, want.result_kind, want.target_out, want.status,
                                 want.last);
                        $display("%0t:          actual   kind=%0d target=%h status=%0d last=%b",
                                 $time, rsp.result_kind, rsp.target_out, rsp.status, rsp.last);
                    end
                    if (want.status == STAT_FULL)
                    begin
                        full_drops++;
                    end
                    if (want.status == STAT_RANGE)
                    begin
                        range_drops++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                wheel_size = cfg_data;
            end
            if (start && !busy)
            begin
                advance_wheel(cmd);
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// ===== test/tb_delay_bin_event_queue.sv =====
`timescale 1ns / 100ps
// testbench top for the delay bin event queue: clock, reset, command and config stimulus
// depends on bdq_pkg, delay_bin_event_queue and the bdq_scoreboard checker

module tb_delay_bin_event_queue;
    import bdq_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int CAPACITY     = BIN_CAPACITY_DEF;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    cmd_t             cmd       = '0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             busy;
    logic             rsp_strobe;
    rsp_t             rsp;
    logic             cfg_ready;

    int fail_count;
    int outstanding;
    int results_seen;
    int full_drops;
    int range_drops;
    int cycle_count = 0;
    int n_items     = 0;
    int n_ticks     = 0;
    int n_settings  = 0;

    delay_bin_event_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .rsp_strobe (rsp_strobe),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    bdq_scoreboard chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .rsp_strobe   (rsp_strobe),
        .rsp          (rsp),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .full_drops   (full_drops),
        .range_drops  (range_drops)
    );

    always #5 clk = ~clk;

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic cmd_t make_cmd(input logic m, input logic [TGT_PORT_W-1:0] tgt,
                                      input logic [DELAY_W-1:0] dly, input logic bl);
        cmd_t c;
        c.mode        = m;
        c.target_in   = tgt;
        c.delay_ticks = dly;
        c.batch_last  = bl;
        return c;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // one command beat, after an optional idle gap
    task automatic send_cmd(input cmd_t c, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        n_items++;
        if (c.mode == MODE_TICK)
        begin
            n_ticks++;
        end
    endtask

    task automatic send_tick(input bit calm);
        send_cmd(make_cmd(MODE_TICK, TGT_PORT_W'($urandom), DELAY_W'($urandom), 1'($urandom)),
                 pick_gap(calm));
    endtask

    // hold off until every predicted result has come back and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
    endtask

    task automatic write_active_bins(input logic [CFG_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // random mix of inserts and ticks for one wheel size
    task automatic random_phase(input int count, input int bins_used, input bit calm);
        cmd_t c;
        int   r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            c = make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), DELAY_W'($urandom), 1'($urandom));
            if (r < 25)
            begin
                c.mode = MODE_TICK;
            end
            else if (r < 88)
            begin
                c.delay_ticks = DELAY_W'($urandom_range(0, bins_used - 1));
            end
            send_cmd(c, pick_gap(calm));
            if ($urandom_range(0, 149) == 0)
            begin
                drain();
            end
        end
    endtask

    initial
    begin
        int wheel_plan [10];
        int bins_used;
        wheel_plan = '{1, 16, 31, 0, 17, 2, 0, 0, 0, 0};
        for (int p = 5; p < 10; p++)
        begin
            wheel_plan[p] = $urandom_range(0, 31);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset wheel of 16: field extremes, two targets in one bin, empty bin
        send_cmd(make_cmd(MODE_INSERT, 16'hFFFF, 4'd0, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'h0000, 4'd15, 1'b1), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'h5A5A, 4'd1, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'h1234, 4'd0, 1'b1), pick_gap(1'b0));
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        send_cmd(make_cmd(MODE_INSERT, 16'hC3C3, 4'd0, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'h8001, 4'd15, 1'b0), pick_gap(1'b0));

        // shrink to 2 bins while the slot sits at 3
        write_active_bins(5'd2);
        send_cmd(make_cmd(MODE_INSERT, 16'h0F0F, 4'd0, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'hF0F0, 4'd1, 1'b1), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'hAAAA, 4'd2, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, 16'h5555, 4'd15, 1'b0), pick_gap(1'b0));
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);

        // zero bins acts as one
        write_active_bins(5'd0);
        send_cmd(make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), 4'd0, 1'b0), pick_gap(1'b0));
        send_cmd(make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), 4'd1, 1'b1), pick_gap(1'b0));
        send_tick(1'b0);
        send_tick(1'b0);

        // largest register value clamps to the full wheel
        write_active_bins(5'd31);
        send_cmd(make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), 4'd15, 1'b0), pick_gap(1'b0));
        send_tick(1'b0);

        // overfill one bin, then a range error aimed at that full bin
        write_active_bins(5'd4);
        for (int i = 0; i < CAPACITY + 3; i++)
        begin
            send_cmd(make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), 4'd2, 1'($urandom)),
                     pick_gap(i < 20));
        end
        send_cmd(make_cmd(MODE_INSERT, TGT_PORT_W'($urandom), 4'd6, 1'b0), pick_gap(1'b0));
        for (int i = 0; i < 4; i++)
        begin
            send_tick(1'b0);
        end

        // random phases over a spread of wheel sizes, one without gaps
        foreach (wheel_plan[p])
        begin
            write_active_bins(CFG_W'(wheel_plan[p]));
            bins_used = (wheel_plan[p] < 1) ? 1 : (wheel_plan[p] > 16) ? 16 : wheel_plan[p];
            random_phase(30, bins_used, p == 1);
        end

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d commands (%0d ticks) over %0d wheel sizes, %0d results",
                 n_items, n_ticks, n_settings, results_seen);
        $display("drops seen: %0d full bin, %0d delay out of range", full_drops, range_drops);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
